// ===== rtl/trial_division_prime_test_macros.svh =====
// Assertion macros for the trial division prime test block.
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define TDP_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tdp assertion failed");
// Next-cycle implication, held off during reset.
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tdp assertion failed");
`else
`define TDP_ASSERT_NOW(label, clk, rst, ante, cons)
`define TDP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/tdp_pkg.sv =====
`timescale 1ns / 1ps
package tdp_pkg;

   localparam int NUMBER_WIDTH = 31;
   // Divisor never exceeds sqrt(number) + 2.
   localparam int DIV_WIDTH    = NUMBER_WIDTH / 2 + 2;
   // Divisor square stays below twice the number range.
   localparam int SQ_WIDTH     = NUMBER_WIDTH + 1;
   localparam int CNT_WIDTH    = $clog2(NUMBER_WIDTH + 1);
   localparam int STEP_WIDTH   = 4;

   typedef logic [STEP_WIDTH-1:0] step_type;

   // Program step addresses.
   localparam step_type STEP_WAIT     = 4'd0;
   localparam step_type STEP_CHK_LT2  = 4'd1;
   localparam step_type STEP_CHK_EQ2  = 4'd2;
   localparam step_type STEP_CHK_EVEN = 4'd3;
   localparam step_type STEP_LOOP     = 4'd4;
   localparam step_type STEP_DIV_INIT = 4'd5;
   localparam step_type STEP_DIV      = 4'd6;
   localparam step_type STEP_CHK_REM  = 4'd7;
   localparam step_type STEP_ADVANCE  = 4'd8;
   localparam step_type STEP_PRIME    = 4'd9;
   localparam step_type STEP_COMPOSITE = 4'd10;
   localparam step_type STEP_EMIT     = 4'd11;
   localparam step_type STEP_RETURN   = 4'd12;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_LOAD,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ADVANCE,
      OP_SET_PRIME,
      OP_SET_COMPOSITE,
      OP_EMIT
   } op_type;

   typedef enum logic [3:0] {
      COND_NEVER,
      COND_ALWAYS,
      COND_NO_REQ,
      COND_LT2,
      COND_EQ2,
      COND_EVEN,
      COND_SQ_GT,
      COND_DIV_BUSY,
      COND_REM_ZERO,
      COND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic no_req;
      logic lt2;
      logic eq2;
      logic even;
      logic sq_gt;
      logic div_busy;
      logic rem_zero;
      logic out_busy;
   } status_type;

   // Microprogram: one control word per step; jump to target when cond holds.
   function automatic ctrl_type tdp_rom(input step_type pc);
      ctrl_type w;
      unique case (pc)
         STEP_WAIT:      w = '{OP_LOAD,          COND_NO_REQ,   STEP_WAIT};
         STEP_CHK_LT2:   w = '{OP_NOP,           COND_LT2,      STEP_COMPOSITE};
         STEP_CHK_EQ2:   w = '{OP_NOP,           COND_EQ2,      STEP_PRIME};
         STEP_CHK_EVEN:  w = '{OP_NOP,           COND_EVEN,     STEP_COMPOSITE};
         STEP_LOOP:      w = '{OP_NOP,           COND_SQ_GT,    STEP_PRIME};
         STEP_DIV_INIT:  w = '{OP_DIV_INIT,      COND_NEVER,    STEP_WAIT};
         STEP_DIV:       w = '{OP_DIV_STEP,      COND_DIV_BUSY, STEP_DIV};
         STEP_CHK_REM:   w = '{OP_NOP,           COND_REM_ZERO, STEP_COMPOSITE};
         STEP_ADVANCE:   w = '{OP_ADVANCE,       COND_ALWAYS,   STEP_LOOP};
         STEP_PRIME:     w = '{OP_SET_PRIME,     COND_ALWAYS,   STEP_EMIT};
         STEP_COMPOSITE: w = '{OP_SET_COMPOSITE, COND_NEVER,    STEP_WAIT};
         STEP_EMIT:      w = '{OP_EMIT,          COND_OUT_BUSY, STEP_EMIT};
         STEP_RETURN:    w = '{OP_NOP,           COND_ALWAYS,   STEP_WAIT};
         default:        w = '{OP_NOP,           COND_ALWAYS,   STEP_WAIT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/trial_division_prime_test.sv =====
`timescale 1ns / 1ps
// Verdicts: 0 and 1 are composite, 2 is prime, other even numbers are composite;
//   an odd number tries each odd divisor from three upward until the divisor square exceeds it
//   (prime) or a divisor divides it (composite); each trial runs init, divide, remainder check, advance.
// Throughput: one beat at a time; the next beat is taken only after the result goes out, via the return step.
//   A ready verdict holds in the emit step while the output register is stalled, and so does intake.
// Reset: synchronous, active high; clears the program counter and the result valid, and sets the divisor to three.
`include "trial_division_prime_test_macros.svh"
module trial_division_prime_test import tdp_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [NUMBER_WIDTH-1:0] req_number,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_is_prime
);

   // Microprogram control and datapath status.
   ctrl_type   ctrl;
   status_type status;

   // Datapath registers.
   logic [NUMBER_WIDTH-1:0] n_ff, n_in;      // number under test
   logic [DIV_WIDTH-1:0]    d_ff, d_in;      // current odd divisor
   logic [SQ_WIDTH-1:0]     sq_ff, sq_in;    // d squared
   logic [NUMBER_WIDTH-1:0] sh_ff, sh_in;    // dividend shifter, MSB first
   logic [DIV_WIDTH-1:0]    rem_ff, rem_in;  // running remainder
   logic [CNT_WIDTH-1:0]    cnt_ff, cnt_in;  // dividend bits left
   logic                    res_ff, res_in;  // verdict awaiting emit
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    rsp_is_prime_ff, rsp_is_prime_in;

   logic [DIV_WIDTH:0]      rem_trial;
   logic                    rem_fits;
   logic                    emit;

   tdp_sequencer u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // Take a beat only in the wait step, and never while in reset.
   assign req_stall = reset || (ctrl.op != OP_LOAD);

   // Shift in the next dividend bit and try a subtract.
   assign rem_trial = {rem_ff, sh_ff[NUMBER_WIDTH-1]};
   assign rem_fits  = (rem_trial >= {1'b0, d_ff});

   // Emit only once the output register is free or being drained.
   assign emit = (ctrl.op == OP_EMIT) && !status.out_busy;

   always_comb begin
      status.no_req   = !req_valid;
      status.lt2      = (n_ff[NUMBER_WIDTH-1:1] == '0);
      status.eq2      = (n_ff == NUMBER_WIDTH'(2));
      status.even     = !n_ff[0];
      status.sq_gt    = (sq_ff > {1'b0, n_ff});
      status.div_busy = (cnt_ff != CNT_WIDTH'(1));
      status.rem_zero = (rem_ff == '0);
      status.out_busy = rsp_valid_ff && rsp_stall;
   end

   always_comb begin
      n_in   = n_ff;
      d_in   = d_ff;
      sq_in  = sq_ff;
      sh_in  = sh_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      res_in = res_ff;
      case (ctrl.op)
         OP_LOAD: begin
            // Capture the number and restart the divisor at three.
            if (req_valid) begin
               n_in  = req_number;
               d_in  = DIV_WIDTH'(3);
               sq_in = SQ_WIDTH'(9);
            end
         end
         OP_DIV_INIT: begin
            sh_in  = n_ff;
            rem_in = '0;
            cnt_in = CNT_WIDTH'(NUMBER_WIDTH);
         end
         OP_DIV_STEP: begin
            rem_in = rem_fits ? DIV_WIDTH'(rem_trial - {1'b0, d_ff})
                              : DIV_WIDTH'(rem_trial);
            sh_in  = {sh_ff[NUMBER_WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_WIDTH'(1);
         end
         OP_ADVANCE: begin
            // (d + 2)^2 = d^2 + 4d + 4
            d_in  = d_ff + DIV_WIDTH'(2);
            sq_in = sq_ff + SQ_WIDTH'({d_ff, 2'b00}) + SQ_WIDTH'(4);
         end
         OP_SET_PRIME:     res_in = 1'b1;
         OP_SET_COMPOSITE: res_in = 1'b0;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_is_prime_in = rsp_is_prime_ff;
      if (emit) begin
         rsp_valid_in    = 1'b1;
         rsp_is_prime_in = res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         d_ff         <= DIV_WIDTH'(3);
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         d_ff         <= d_in;
      end
   end

   // Payload registers: no reset.
   always_ff @(posedge clock) begin
      n_ff            <= n_in;
      sq_ff           <= sq_in;
      sh_ff           <= sh_in;
      rem_ff          <= rem_in;
      cnt_ff          <= cnt_in;
      res_ff          <= res_in;
      rsp_is_prime_ff <= rsp_is_prime_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_is_prime = rsp_is_prime_ff;

   // Keep the remainder below the divisor through every subtract step.
   `TDP_ASSERT_NEXT(a_rem_below_div, clock, reset, ctrl.op == OP_DIV_STEP, rem_ff < d_ff)
   // Trial divisors stay odd.
   `TDP_ASSERT_NOW(a_div_odd, clock, reset, 1'b1, d_ff[0])
   // A prime verdict never goes out for an even number other than two.
   `TDP_ASSERT_NOW(a_prime_odd, clock, reset, emit && res_ff,
                   n_ff[0] || (n_ff == NUMBER_WIDTH'(2)))

endmodule

// ===== rtl/tdp_sequencer.sv =====
`timescale 1ns / 1ps
module tdp_sequencer import tdp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  status_type status,
   output ctrl_type   ctrl
);

   step_type pc_ff;
   step_type pc_in;
   logic     take;

   assign ctrl = tdp_rom(pc_ff);

   always_comb begin
      unique case (ctrl.cond)
         COND_NEVER:    take = 1'b0;
         COND_ALWAYS:   take = 1'b1;
         COND_NO_REQ:   take = status.no_req;
         COND_LT2:      take = status.lt2;
         COND_EQ2:      take = status.eq2;
         COND_EVEN:     take = status.even;
         COND_SQ_GT:    take = status.sq_gt;
         COND_DIV_BUSY: take = status.div_busy;
         COND_REM_ZERO: take = status.rem_zero;
         COND_OUT_BUSY: take = status.out_busy;
         default:       take = 1'b0;
      endcase
   end

   // Jump on a true condition, otherwise advance.
   assign pc_in = take ? ctrl.target : pc_ff + step_type'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= STEP_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
